### rtl/core/sol_pkg.sv
`timescale 1ns / 1ps

package sol_pkg;

    localparam logic [2:0] CMD_INS_HEAD  = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [2:0] CMD_REM_HEAD  = 3'd2;
    localparam logic [2:0] CMD_REM_TAIL  = 3'd3;
    localparam logic [2:0] CMD_SEARCH    = 3'd4;
    localparam logic [2:0] CMD_MTF       = 3'd5;
    localparam logic [2:0] CMD_TRANSPOSE = 3'd6;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_ATHEAD   = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INS_HEAD,
        OP_INS_TAIL,
        OP_REM_HEAD,
        OP_REM_TAIL,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_TP_FIRST,
        OP_TP_SECOND,
        OP_MTF_START,
        OP_SHIFT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_pos;
    } dp_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       match;
        logic       last;
        logic       cidx_zero;
        logic       widx_zero;
        logic [2:0] cmd;
    } dp_stat_t;

endpackage

### rtl/core/sol_dp.sv
`timescale 1ns / 1ps

module sol_dp #(
    parameter int DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [2:0]       in_cmd,
    input  logic [31:0]      in_key,
    input  sol_pkg::dp_cmd_t ctl,
    output sol_pkg::dp_stat_t stat,
    output logic [2:0]       out_status,
    output logic [3:0]       out_position,
    output logic [4:0]       out_length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cidx_reg, cidx_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic [31:0]   prev_reg, prev_next;
    logic [31:0]   key_reg, key_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   rdata_reg;
    logic [2:0]    status_reg;
    logic [3:0]    pos_reg;
    logic [4:0]    len_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;

    logic [AW-1:0] head_dec, head_inc;
    logic [AW-1:0] cidx_p1, cidx_m1, cidx_m2, widx_m1, widx_m2;
    logic          cidx_ge2, widx_ge2;
    logic [AW+3:0] pos_ext;
    logic [CW+4:0] len_ext;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] offs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign cidx_p1  = cidx_reg + AW'(1);
    assign cidx_m1  = cidx_reg - AW'(1);
    assign cidx_m2  = cidx_reg - AW'(2);
    assign widx_m1  = widx_reg - AW'(1);
    assign widx_m2  = widx_reg - AW'(2);
    assign cidx_ge2 = {1'b0, cidx_reg} >= (AW+1)'(2);
    assign widx_ge2 = {1'b0, widx_reg} >= (AW+1)'(2);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        cidx_next  = cidx_reg;
        widx_next  = widx_reg;
        prev_next  = prev_reg;
        key_next   = key_reg;
        cmd_next   = cmd_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = key_reg;
        re         = 1'b0;
        raddr      = '0;
        case (ctl.op)
            sol_pkg::OP_LOAD: begin
                cmd_next = in_cmd;
                key_next = in_key;
            end
            sol_pkg::OP_INS_HEAD: begin
                head_next  = head_dec;
                we         = 1'b1;
                waddr      = head_dec;
                count_next = count_reg + CW'(1);
            end
            sol_pkg::OP_INS_TAIL: begin
                we         = 1'b1;
                waddr      = phys(head_reg, count_reg[AW-1:0]);
                count_next = count_reg + CW'(1);
            end
            sol_pkg::OP_REM_HEAD: begin
                head_next  = head_inc;
                count_next = count_reg - CW'(1);
            end
            sol_pkg::OP_REM_TAIL: begin
                count_next = count_reg - CW'(1);
            end
            sol_pkg::OP_SCAN_START: begin
                cidx_next = '0;
                re        = 1'b1;
                raddr     = head_reg;
            end
            sol_pkg::OP_SCAN_NEXT: begin
                prev_next = rdata_reg;
                cidx_next = cidx_p1;
                re        = 1'b1;
                raddr     = phys(head_reg, cidx_p1);
            end
            sol_pkg::OP_TP_FIRST: begin
                we    = 1'b1;
                waddr = phys(head_reg, cidx_reg);
                wdata = prev_reg;
            end
            sol_pkg::OP_TP_SECOND: begin
                we    = 1'b1;
                waddr = phys(head_reg, cidx_m1);
                wdata = key_reg;
            end
            sol_pkg::OP_MTF_START: begin
                we        = 1'b1;
                waddr     = phys(head_reg, cidx_reg);
                wdata     = prev_reg;
                widx_next = cidx_m1;
                re        = 1'b1;
                raddr     = phys(head_reg, cidx_ge2 ? cidx_m2 : '0);
            end
            sol_pkg::OP_SHIFT: begin
                we = 1'b1;
                if (widx_reg == '0) begin
                    waddr = head_reg;
                    wdata = key_reg;
                end else begin
                    waddr     = phys(head_reg, widx_reg);
                    wdata     = rdata_reg;
                    widx_next = widx_m1;
                    re        = 1'b1;
                    raddr     = phys(head_reg, widx_ge2 ? widx_m2 : '0);
                end
            end
            default: begin
            end
        endcase
    end

    assign pos_ext = {4'b0, cidx_reg};
    assign len_ext = {5'b0, count_next};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        cidx_reg <= cidx_next;
        widx_reg <= widx_next;
        prev_reg <= prev_next;
        key_reg  <= key_next;
        cmd_reg  <= cmd_next;
        if (ctl.res_load) begin
            status_reg <= ctl.res_status;
            pos_reg    <= ctl.res_pos ? pos_ext[3:0] : 4'd0;
            len_reg    <= len_ext[4:0];
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.match     = (rdata_reg == key_reg);
    assign stat.last      = ((CW'(cidx_reg) + CW'(1)) == count_reg);
    assign stat.cidx_zero = (cidx_reg == '0);
    assign stat.widx_zero = (widx_reg == '0);
    assign stat.cmd       = cmd_reg;

    assign out_status   = status_reg;
    assign out_position = pos_reg;
    assign out_length   = len_reg;

endmodule

### rtl/core/sol_ctrl.sv
`timescale 1ns / 1ps

module sol_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sol_pkg::dp_stat_t stat,
    output sol_pkg::dp_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_TP2,
        S_SHIFT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        ctl.op         = sol_pkg::OP_NONE;
        ctl.res_load   = 1'b0;
        ctl.res_status = sol_pkg::STAT_OK;
        ctl.res_pos    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.op     = sol_pkg::OP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (stat.cmd)
                    sol_pkg::CMD_INS_HEAD, sol_pkg::CMD_INS_TAIL: begin
                        if (out_free) begin
                            ctl.res_load = 1'b1;
                            state_next   = S_IDLE;
                            if (stat.full) begin
                                ctl.res_status = sol_pkg::STAT_FULL;
                            end else begin
                                ctl.op = (stat.cmd == sol_pkg::CMD_INS_HEAD) ?
                                         sol_pkg::OP_INS_HEAD : sol_pkg::OP_INS_TAIL;
                            end
                        end
                    end
                    sol_pkg::CMD_REM_HEAD, sol_pkg::CMD_REM_TAIL: begin
                        if (out_free) begin
                            ctl.res_load = 1'b1;
                            state_next   = S_IDLE;
                            if (stat.empty) begin
                                ctl.res_status = sol_pkg::STAT_EMPTY;
                            end else begin
                                ctl.op = (stat.cmd == sol_pkg::CMD_REM_HEAD) ?
                                         sol_pkg::OP_REM_HEAD : sol_pkg::OP_REM_TAIL;
                            end
                        end
                    end
                    sol_pkg::CMD_SEARCH, sol_pkg::CMD_MTF, sol_pkg::CMD_TRANSPOSE: begin
                        if (!stat.empty) begin
                            ctl.op     = sol_pkg::OP_SCAN_START;
                            state_next = S_SCAN;
                        end else if (out_free) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = sol_pkg::STAT_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            ctl.res_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.match) begin
                    if (stat.cmd == sol_pkg::CMD_MTF && !stat.cidx_zero) begin
                        ctl.op     = sol_pkg::OP_MTF_START;
                        state_next = S_SHIFT;
                    end else if (stat.cmd == sol_pkg::CMD_TRANSPOSE && !stat.cidx_zero) begin
                        ctl.op     = sol_pkg::OP_TP_FIRST;
                        state_next = S_TP2;
                    end else if (out_free) begin
                        ctl.res_load = 1'b1;
                        ctl.res_pos  = 1'b1;
                        state_next   = S_IDLE;
                        if (stat.cmd == sol_pkg::CMD_TRANSPOSE) begin
                            ctl.res_status = sol_pkg::STAT_ATHEAD;
                        end
                    end
                end else if (stat.last) begin
                    if (out_free) begin
                        ctl.res_load   = 1'b1;
                        ctl.res_status = sol_pkg::STAT_NOTFOUND;
                        state_next     = S_IDLE;
                    end
                end else begin
                    ctl.op = sol_pkg::OP_SCAN_NEXT;
                end
            end
            S_TP2: begin
                if (out_free) begin
                    ctl.op       = sol_pkg::OP_TP_SECOND;
                    ctl.res_load = 1'b1;
                    ctl.res_pos  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!stat.widx_zero) begin
                    ctl.op = sol_pkg::OP_SHIFT;
                end else if (out_free) begin
                    ctl.op       = sol_pkg::OP_SHIFT;
                    ctl.res_load = 1'b1;
                    ctl.res_pos  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_tvalid_next = ctl.res_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### rtl/core/self_organizing_list.sv
// A search scans the list from the head and stops at the first match or at its end;
// transpose then swaps the match with its predecessor, and move-to-front shifts the
// entries ahead of the match down one by one and writes the key at the head.
// One request is in progress at a time; the next is accepted once the previous has finished.
// Reset (aresetn low, synchronous) empties the list; the entry RAM itself is not cleared.
`timescale 1ns / 1ps

module self_organizing_list #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] key
    input  logic [2:0]  s_tuser,  // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [2:0] status, [6:3] position, [11:7] length, rest zero
);

    sol_pkg::dp_cmd_t  ctl;
    sol_pkg::dp_stat_t stat;
    logic [2:0] res_status;
    logic [3:0] res_position;
    logic [4:0] res_length;

    sol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sol_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_cmd       (s_tuser),
        .in_key       (s_tdata),
        .ctl          (ctl),
        .stat         (stat),
        .out_status   (res_status),
        .out_position (res_position),
        .out_length   (res_length)
    );

    assign m_tdata = {4'b0, res_length, res_position, res_status};

endmodule

### tb/sv/self_organizing_list_tb.sv
`timescale 1ns / 1ps

module self_organizing_list_tb;

    localparam int LIST_DEPTH = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam logic [2:0] CMD_NOP = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    typedef struct {
        logic [2:0] status;
        logic [3:0] position;
        logic [4:0] length;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  keys [LIST_DEPTH];
        int           count;
        list_result_t expected_q [$];
        int           failures;

        function new();
            count = 0;
            failures = 0;
        endfunction

        function void note_request(logic [2:0] cmd, logic [31:0] key);
            list_result_t r;
            logic [31:0]  moved;
            int           hit;
            r.status = sol_pkg::STAT_OK;
            r.position = 4'd0;
            case (cmd)
                sol_pkg::CMD_INS_HEAD, sol_pkg::CMD_INS_TAIL: begin
                    if (count >= LIST_DEPTH) begin
                        r.status = sol_pkg::STAT_FULL;
                    end else if (cmd == sol_pkg::CMD_INS_HEAD) begin
                        for (int i = count; i > 0; i--) keys[i] = keys[i - 1];
                        keys[0] = key;
                        count++;
                    end else begin
                        keys[count] = key;
                        count++;
                    end
                end
                sol_pkg::CMD_REM_HEAD, sol_pkg::CMD_REM_TAIL: begin
                    if (count == 0) begin
                        r.status = sol_pkg::STAT_EMPTY;
                    end else begin
                        if (cmd == sol_pkg::CMD_REM_HEAD) begin
                            for (int i = 0; i + 1 < count; i++) keys[i] = keys[i + 1];
                        end
                        count--;
                    end
                end
                sol_pkg::CMD_SEARCH, sol_pkg::CMD_MTF, sol_pkg::CMD_TRANSPOSE: begin
                    if (count == 0) begin
                        r.status = sol_pkg::STAT_EMPTY;
                    end else begin
                        hit = count;
                        for (int i = count - 1; i >= 0; i--) begin
                            if (keys[i] == key) hit = i;
                        end
                        if (hit == count) begin
                            r.status = sol_pkg::STAT_NOTFOUND;
                        end else begin
                            r.position = hit[3:0];
                            if (cmd == sol_pkg::CMD_MTF && hit > 0) begin
                                moved = keys[hit];
                                for (int i = hit; i > 0; i--) keys[i] = keys[i - 1];
                                keys[0] = moved;
                            end else if (cmd == sol_pkg::CMD_TRANSPOSE) begin
                                if (hit == 0) begin
                                    r.status = sol_pkg::STAT_ATHEAD;
                                end else begin
                                    moved = keys[hit];
                                    keys[hit] = keys[hit - 1];
                                    keys[hit - 1] = moved;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            r.length = count[4:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            list_result_t exp_r;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Unexpected result %h with no request pending", data);
                end
            end else begin
                exp_r = expected_q.pop_front();
                if (data[2:0] !== exp_r.status || data[6:3] !== exp_r.position ||
                    data[11:7] !== exp_r.length) begin
                    failures++;
                    if (failures <= 10) begin
                        $display({"Mismatch: expected status %0d position %0d length %0d, ",
                                  "got %0d %0d %0d"},
                                 exp_r.status, exp_r.position, exp_r.length,
                                 data[2:0], data[6:3], data[11:7]);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    list_scoreboard sb;
    int             burst_left;
    int             idle_cycles;

    self_organizing_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_request(input logic [2:0] cmd, input logic [31:0] key);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= key;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_insert_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 32'($urandom_range(0, 7));
        if (r < 50) return pick_extreme();
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_lookup_key();
        if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
            return sb.keys[$urandom_range(0, sb.count - 1)];
        end
        return pick_insert_key();
    endfunction

    task automatic send_random(input int bias);
        int         r;
        int         ins_cut;
        int         rem_cut;
        logic [2:0] cmd;
        logic [31:0] key;
        r = $urandom_range(0, 99);
        ins_cut = bias == 0 ? 70 : (bias == 1 ? 20 : 30);
        rem_cut = bias == 0 ? 80 : (bias == 1 ? 70 : 45);
        if (r < ins_cut) begin
            cmd = $urandom_range(0, 1) ? sol_pkg::CMD_INS_HEAD : sol_pkg::CMD_INS_TAIL;
            key = pick_insert_key();
        end else if (r < rem_cut) begin
            cmd = $urandom_range(0, 1) ? sol_pkg::CMD_REM_HEAD : sol_pkg::CMD_REM_TAIL;
            key = $urandom;
        end else if (r < 97) begin
            case ($urandom_range(0, 2))
                0: cmd = sol_pkg::CMD_SEARCH;
                1: cmd = sol_pkg::CMD_MTF;
                default: cmd = sol_pkg::CMD_TRANSPOSE;
            endcase
            key = pick_lookup_key();
        end else begin
            cmd = CMD_NOP;
            key = $urandom;
        end
        send_request(cmd, key);
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        s_tuser = CMD_NOP;
        burst_left = 4;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(sol_pkg::CMD_REM_HEAD, 32'd0);
        send_request(sol_pkg::CMD_REM_TAIL, 32'd0);
        send_request(sol_pkg::CMD_SEARCH, 32'd0);
        send_request(sol_pkg::CMD_MTF, 32'd0);
        send_request(sol_pkg::CMD_TRANSPOSE, 32'd0);
        send_request(CMD_NOP, 32'hFFFF_FFFF);
        send_request(sol_pkg::CMD_INS_HEAD, 32'h8000_0000);
        send_request(sol_pkg::CMD_INS_TAIL, 32'h7FFF_FFFF);
        send_request(sol_pkg::CMD_INS_HEAD, 32'h0000_0000);
        send_request(sol_pkg::CMD_INS_TAIL, 32'hFFFF_FFFF);
        send_request(sol_pkg::CMD_INS_HEAD, 32'h7FFF_FFFF);
        send_request(sol_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(sol_pkg::CMD_SEARCH, 32'h1234_5678);
        send_request(sol_pkg::CMD_MTF, 32'h7FFF_FFFF);
        send_request(sol_pkg::CMD_TRANSPOSE, 32'h7FFF_FFFF);
        send_request(sol_pkg::CMD_TRANSPOSE, 32'hFFFF_FFFF);
        send_request(sol_pkg::CMD_MTF, 32'hFFFF_FFFF);
        send_request(CMD_NOP, 32'h0000_0000);
        send_request(sol_pkg::CMD_REM_HEAD, 32'd0);
        send_request(sol_pkg::CMD_REM_TAIL, 32'd0);
        send_request(sol_pkg::CMD_REM_TAIL, 32'd0);
        send_request(sol_pkg::CMD_REM_TAIL, 32'd0);
        send_request(sol_pkg::CMD_REM_TAIL, 32'd0);

        for (int p = 0; p < PHASES; p++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) send_random(p % 3);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("self_organizing_list regression: pass");
        end else begin
            $display("self_organizing_list regression: fail");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    initial begin
        int mode;
        int mode_left;
        int step;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        step = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            step++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (step % 8) >= 5;
            endcase
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("self_organizing_list regression: fail");
                $finish;
            end
        end
    end

endmodule
